@@ hdl/ptss_pkg.sv @@
// shared types, codes and constants of the pan/tilt servo slew controller
// no dependencies; imported by every module of the block
`default_nettype none
package ptss_pkg;

	localparam int ANGLE_W      = 8;
	localparam int PULSE_W      = 12;
	localparam int COUNT_W      = 16;
	localparam int COORD_W      = 13;
	localparam int CELL_W       = 4;
	localparam int REQ_W        = 2;
	localparam int MODE_W       = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam int COORD_FRAC_BITS = 12;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
	localparam logic [ANGLE_W-1:0] RESET_ANGLE = 8'd90;

	// request codes
	localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEFAULT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_GRID    = 2'd2;
	localparam logic [REQ_W-1:0] REQ_TRACK   = 2'd3;

	// control modes
	localparam logic [MODE_W-1:0] CM_IDLE  = 2'd0;
	localparam logic [MODE_W-1:0] CM_GRID  = 2'd1;
	localparam logic [MODE_W-1:0] CM_TRACK = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STEP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_PAN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_TILT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT     = 3'd6;

	// register reset values
	localparam logic [ANGLE_W-1:0] RST_STEP      = 8'd3;
	localparam logic [COUNT_W-1:0] RST_TIMEOUT   = 16'd50;
	localparam logic [PULSE_W-1:0] RST_PULSE_MIN = 12'd1000;
	localparam logic [PULSE_W-1:0] RST_PULSE_MAX = 12'd2000;
	localparam logic [ANGLE_W-1:0] RST_DEFAULT   = 8'd90;

	// pulse math: n = span*deg + 90 fits 20 bits, then n/180 = (n>>2)/45
	localparam int PROD_W   = PULSE_W + ANGLE_W;
	localparam int QUART_W  = PROD_W - 2;
	localparam int RECIP_SH = 24;
	localparam int RECIP_W  = 19;
	localparam logic [RECIP_W-1:0] RECIP_45 = 19'd372828;
	localparam logic [PROD_W-1:0]  HALF_180 = 20'd90;

	localparam logic [ANGLE_W-1:0] PRESET_PAN  [3] = '{8'd30, 8'd90, 8'd150};
	localparam logic [ANGLE_W-1:0] PRESET_TILT [3] = '{8'd120, 8'd90, 8'd60};

	typedef struct packed {
		logic                load;
		logic                slew;
		logic [ANGLE_W-1:0]  target;
	} lane_cmd_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} pipe_en_t;

endpackage
`default_nettype wire

@@ hdl/ptss_ctrl.sv @@
// request decode: mode, track timeout counter, grid presets and track mapping
// depends on ptss_pkg; drives one command per axis lane
`default_nettype none
module ptss_ctrl
	import ptss_pkg::*;
#(
	parameter int CoordFracBits = COORD_FRAC_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 accept,
	input  wire logic [REQ_W-1:0]     req_type,
	input  wire logic [CELL_W-1:0]    grid_cell,
	input  wire logic [COORD_W-1:0]   track_x,
	input  wire logic [COORD_W-1:0]   track_y,
	input  wire logic [COUNT_W-1:0]   timeout_periods,
	input  wire logic [ANGLE_W-1:0]   default_angle,
	output lane_cmd_t                 pan_cmd,
	output lane_cmd_t                 tilt_cmd,
	output logic [MODE_W-1:0]         mode_s1,
	output logic                      ignored_s1
);

	localparam int VW = (CoordFracBits + 1 > COORD_W) ? CoordFracBits + 1 : COORD_W;
	localparam int PW = VW + ANGLE_W;
	localparam logic [VW-1:0] ONE  = VW'(1) << CoordFracBits;
	localparam logic [PW-1:0] HALF = PW'(1) << (CoordFracBits - 1);

	function automatic logic [ANGLE_W-1:0] coord_deg(input logic [COORD_W-1:0] c);
		logic [VW-1:0] v;
		logic [PW-1:0] p;
		v = VW'(c);
		if (v > ONE) begin
			v = ONE;
		end
		p = PW'(ANGLE_MAX) * PW'(v) + HALF;
		return ANGLE_W'(p >> CoordFracBits);
	endfunction

	logic [MODE_W-1:0]  mode_q, mode_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic [ANGLE_W-1:0] def_sat;
	logic               is_tick, grid_ok, to_default;
	logic [1:0]         col, row;

	assign is_tick = (req_type == REQ_TICK);
	assign def_sat = (default_angle > ANGLE_MAX) ? ANGLE_MAX : default_angle;
	assign grid_ok = (grid_cell >= CELL_W'(1)) && (grid_cell <= CELL_W'(9));

	// cell 1..9 row-major
	always_comb begin
		case (grid_cell)
			4'd1, 4'd4, 4'd7: col = 2'd0;
			4'd2, 4'd5, 4'd8: col = 2'd1;
			default:          col = 2'd2;
		endcase
		case (grid_cell)
			4'd1, 4'd2, 4'd3: row = 2'd0;
			4'd4, 4'd5, 4'd6: row = 2'd1;
			default:          row = 2'd2;
		endcase
	end

	always_comb begin
		cnt_d      = cnt_q;
		mode_d     = mode_q;
		to_default = 1'b0;
		pan_cmd    = '{load: 1'b0, slew: 1'b0, target: def_sat};
		tilt_cmd   = '{load: 1'b0, slew: 1'b0, target: def_sat};
		case (req_type)
			REQ_TICK: begin
				if (cnt_q != {COUNT_W{1'b1}}) begin
					cnt_d = cnt_q + COUNT_W'(1);
				end
				to_default = (mode_q == CM_TRACK) && (cnt_d > timeout_periods);
			end
			REQ_DEFAULT: begin
				to_default = 1'b1;
			end
			REQ_GRID: begin
				if (grid_ok) begin
					mode_d          = CM_GRID;
					pan_cmd.load    = 1'b1;
					pan_cmd.target  = PRESET_PAN[col];
					tilt_cmd.load   = 1'b1;
					tilt_cmd.target = PRESET_TILT[row];
				end
			end
			REQ_TRACK: begin
				mode_d          = CM_TRACK;
				cnt_d           = '0;
				pan_cmd.load    = 1'b1;
				pan_cmd.target  = coord_deg(track_x);
				tilt_cmd.load   = 1'b1;
				tilt_cmd.target = coord_deg(track_y);
			end
			default: begin
			end
		endcase
		if (to_default) begin
			mode_d        = CM_IDLE;
			pan_cmd.load  = 1'b1;
			tilt_cmd.load = 1'b1;
		end
		pan_cmd.slew  = is_tick;
		tilt_cmd.slew = is_tick;
		if (!accept) begin
			pan_cmd.load  = 1'b0;
			pan_cmd.slew  = 1'b0;
			tilt_cmd.load = 1'b0;
			tilt_cmd.slew = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= CM_IDLE;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1    <= mode_d;
			ignored_s1 <= (req_type == REQ_GRID) && !grid_ok;
		end
	end

endmodule
`default_nettype wire

@@ hdl/ptss_axis_lane.sv @@
// one servo axis: target and angle state, slew step and pulse scaling pipeline
// depends on ptss_pkg; two copies run side by side for pan and tilt
`default_nettype none
module ptss_axis_lane
	import ptss_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lane_cmd_t            cmd,
	input  wire pipe_en_t             en,
	input  wire logic [ANGLE_W-1:0]   slew_step,
	input  wire logic                 invert,
	input  wire logic [PULSE_W-1:0]   span,
	output logic [ANGLE_W-1:0]        angle_s3,
	output logic [PULSE_W-1:0]        frac_s3
);

	logic [ANGLE_W-1:0] target_q, angle_q;
	logic [ANGLE_W-1:0] tgt_eff, angle_d, diff;
	logic [ANGLE_W-1:0] angle_s1, angle_s2, deg;
	logic [PROD_W-1:0]  num_s2;
	logic [QUART_W+RECIP_W-1:0] quot;

	assign tgt_eff = cmd.load ? cmd.target : target_q;

	always_comb begin
		angle_d = angle_q;
		diff    = '0;
		if (cmd.slew) begin
			if (angle_q < tgt_eff) begin
				diff    = tgt_eff - angle_q;
				angle_d = (diff > slew_step) ? angle_q + slew_step : tgt_eff;
			end else if (angle_q > tgt_eff) begin
				diff    = angle_q - tgt_eff;
				angle_d = (diff > slew_step) ? angle_q - slew_step : tgt_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= RESET_ANGLE;
			angle_q  <= RESET_ANGLE;
		end else begin
			target_q <= tgt_eff;
			angle_q  <= angle_d;
		end
	end

	always_comb begin
		deg = (angle_s1 > ANGLE_MAX) ? ANGLE_MAX : angle_s1;
		if (invert) begin
			deg = ANGLE_MAX - deg;
		end
	end

	// divide by 180 as a shift by two and a reciprocal multiply for 45
	assign quot = (QUART_W + RECIP_W)'(num_s2[PROD_W-1:2]) * (QUART_W + RECIP_W)'(RECIP_45);

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			angle_s1 <= angle_d;
		end
		if (en.en_s2) begin
			angle_s2 <= angle_s1;
			num_s2   <= PROD_W'(span) * PROD_W'(deg) + HALF_180;
		end
		if (en.en_s3) begin
			angle_s3 <= angle_s2;
			frac_s3  <= quot[RECIP_SH +: PULSE_W];
		end
	end

endmodule
`default_nettype wire

@@ hdl/ptss_merge.sv @@
// pipeline flow control and the output stage that joins both lanes into one word
// depends on ptss_pkg; steers the stage enables of the axis lanes
`default_nettype none
module ptss_merge
	import ptss_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	output logic                      accept,
	output pipe_en_t                  en,
	input  wire logic [MODE_W-1:0]    mode_s1,
	input  wire logic                 ignored_s1,
	input  wire logic [PULSE_W-1:0]   pulse_base,
	input  wire logic [ANGLE_W-1:0]   pan_angle_s3,
	input  wire logic [PULSE_W-1:0]   pan_frac_s3,
	input  wire logic [ANGLE_W-1:0]   tilt_angle_s3,
	input  wire logic [PULSE_W-1:0]   tilt_frac_s3,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [PULSE_W-1:0]        pan_pulse_us,
	output logic [PULSE_W-1:0]        tilt_pulse_us,
	output logic [ANGLE_W-1:0]        pan_now,
	output logic [ANGLE_W-1:0]        tilt_now,
	output logic [MODE_W-1:0]         mode_now,
	output logic                      request_ignored
);

	logic v1_q, v2_q, v3_q;
	logic rdy_o, rdy3, rdy2, rdy1, en_o;
	logic [MODE_W-1:0] mode_s2, mode_s3;
	logic              ignored_s2, ignored_s3;

	// each stage moves on when the next one is empty or moving
	assign rdy_o     = !out_valid || !out_stall;
	assign rdy3      = !v3_q || rdy_o;
	assign rdy2      = !v2_q || rdy3;
	assign rdy1      = !v1_q || rdy2;
	assign in_stall  = !rdy1;
	assign accept    = in_valid && rdy1;
	assign en.en_s1  = accept;
	assign en.en_s2  = v1_q && rdy2;
	assign en.en_s3  = v2_q && rdy3;
	assign en_o      = v3_q && rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v1_q      <= accept || (v1_q && !rdy2);
			v2_q      <= en.en_s2 || (v2_q && !rdy3);
			v3_q      <= en.en_s3 || (v3_q && !rdy_o);
			out_valid <= en_o || (out_valid && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			mode_s2    <= mode_s1;
			ignored_s2 <= ignored_s1;
		end
		if (en.en_s3) begin
			mode_s3    <= mode_s2;
			ignored_s3 <= ignored_s2;
		end
		if (en_o) begin
			pan_pulse_us    <= pulse_base + pan_frac_s3;
			tilt_pulse_us   <= pulse_base + tilt_frac_s3;
			pan_now         <= pan_angle_s3;
			tilt_now        <= tilt_angle_s3;
			mode_now        <= mode_s3;
			request_ignored <= ignored_s3;
		end
	end

endmodule
`default_nettype wire

@@ hdl/pan_tilt_servo_slew_controller_core.sv @@
// top level of the pan/tilt servo slew controller: registers, lanes, output stage
// depends on ptss_pkg, ptss_ctrl, ptss_axis_lane and ptss_merge
//
// channel   handshake               payload
// in        in_valid / in_stall     req_type, grid_cell, track_x, track_y
// out       out_valid / out_stall   pan/tilt_pulse_us, pan/tilt_now, mode_now,
//                                   request_ignored
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one item per cycle unless out_stall holds it; a word passes s1, s2, s3 and
// the output register; angle state updates in the accept cycle, the pulse scaling
// behind it runs in a multiply stage and a reciprocal multiply stage per lane
// reset clears all control state at once; no clearing pass
// out_stall backs up through the output register and three stages; in_stall
// rises only when all four hold a word
`default_nettype none
module pan_tilt_servo_slew_controller_core
	import ptss_pkg::*;
#(
	parameter int CoordFracBits = COORD_FRAC_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [REQ_W-1:0]       req_type,
	input  wire logic [CELL_W-1:0]      grid_cell,
	input  wire logic [COORD_W-1:0]     track_x,
	input  wire logic [COORD_W-1:0]     track_y,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [PULSE_W-1:0]          pan_pulse_us,
	output logic [PULSE_W-1:0]          tilt_pulse_us,
	output logic [ANGLE_W-1:0]          pan_now,
	output logic [ANGLE_W-1:0]          tilt_now,
	output logic [MODE_W-1:0]           mode_now,
	output logic                        request_ignored,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [ANGLE_W-1:0] step_q, default_q;
	logic [COUNT_W-1:0] timeout_q;
	logic [PULSE_W-1:0] pmin_q, pmax_q, span;
	logic               inv_pan_q, inv_tilt_q;

	logic               accept;
	pipe_en_t           en;
	lane_cmd_t          pan_cmd, tilt_cmd;
	logic [MODE_W-1:0]  mode_s1;
	logic               ignored_s1;
	logic [ANGLE_W-1:0] pan_angle_s3, tilt_angle_s3;
	logic [PULSE_W-1:0] pan_frac_s3, tilt_frac_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= RST_STEP;
			timeout_q  <= RST_TIMEOUT;
			pmin_q     <= RST_PULSE_MIN;
			pmax_q     <= RST_PULSE_MAX;
			inv_pan_q  <= 1'b1;
			inv_tilt_q <= 1'b1;
			default_q  <= RST_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP:        step_q     <= cfg_data[ANGLE_W-1:0];
				REG_TIMEOUT:     timeout_q  <= cfg_data[COUNT_W-1:0];
				REG_PULSE_MIN:   pmin_q     <= cfg_data[PULSE_W-1:0];
				REG_PULSE_MAX:   pmax_q     <= cfg_data[PULSE_W-1:0];
				REG_INVERT_PAN:  inv_pan_q  <= cfg_data[0];
				REG_INVERT_TILT: inv_tilt_q <= cfg_data[0];
				REG_DEFAULT:     default_q  <= cfg_data[ANGLE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// a reversed range pins both pulses to the minimum
	assign span = (pmax_q >= pmin_q) ? pmax_q - pmin_q : '0;

	ptss_ctrl #(
		.CoordFracBits(CoordFracBits)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.req_type        (req_type),
		.grid_cell       (grid_cell),
		.track_x         (track_x),
		.track_y         (track_y),
		.timeout_periods (timeout_q),
		.default_angle   (default_q),
		.pan_cmd         (pan_cmd),
		.tilt_cmd        (tilt_cmd),
		.mode_s1         (mode_s1),
		.ignored_s1      (ignored_s1)
	);

	ptss_axis_lane u_pan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (pan_cmd),
		.en        (en),
		.slew_step (step_q),
		.invert    (inv_pan_q),
		.span      (span),
		.angle_s3  (pan_angle_s3),
		.frac_s3   (pan_frac_s3)
	);

	ptss_axis_lane u_tilt (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tilt_cmd),
		.en        (en),
		.slew_step (step_q),
		.invert    (inv_tilt_q),
		.span      (span),
		.angle_s3  (tilt_angle_s3),
		.frac_s3   (tilt_frac_s3)
	);

	ptss_merge u_merge (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.accept          (accept),
		.en              (en),
		.mode_s1         (mode_s1),
		.ignored_s1      (ignored_s1),
		.pulse_base      (pmin_q),
		.pan_angle_s3    (pan_angle_s3),
		.pan_frac_s3     (pan_frac_s3),
		.tilt_angle_s3   (tilt_angle_s3),
		.tilt_frac_s3    (tilt_frac_s3),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pan_pulse_us    (pan_pulse_us),
		.tilt_pulse_us   (tilt_pulse_us),
		.pan_now         (pan_now),
		.tilt_now        (tilt_now),
		.mode_now        (mode_now),
		.request_ignored (request_ignored)
	);

endmodule
`default_nettype wire

@@ hdl/ptss_checker.sv @@
// port-level checks of the pan/tilt servo slew controller, bound to the top level
// depends on ptss_pkg and pan_tilt_servo_slew_controller_core
`default_nettype none
module ptss_port_props
	import ptss_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [PULSE_W-1:0]    pan_pulse_us,
	input wire logic [PULSE_W-1:0]    tilt_pulse_us,
	input wire logic [ANGLE_W-1:0]    pan_now,
	input wire logic [ANGLE_W-1:0]    tilt_now,
	input wire logic [MODE_W-1:0]     mode_now,
	input wire logic                  request_ignored,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready
);

	// a held word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pan_pulse_us)
			&& $stable(tilt_pulse_us) && $stable(pan_now) && $stable(tilt_now)
			&& $stable(mode_now) && $stable(request_ignored))
		else $error("output word changed while stalled");

	// with the output register empty the pipeline has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_angles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pan_now <= ANGLE_MAX && tilt_now <= ANGLE_MAX)
		else $error("angle out of range");

	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mode_now == CM_IDLE || mode_now == CM_GRID
			|| mode_now == CM_TRACK)
		else $error("bad mode code");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

endmodule

bind pan_tilt_servo_slew_controller_core ptss_port_props u_port_props (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.pan_pulse_us    (pan_pulse_us),
	.tilt_pulse_us   (tilt_pulse_us),
	.pan_now         (pan_now),
	.tilt_now        (tilt_now),
	.mode_now        (mode_now),
	.request_ignored (request_ignored),
	.cfg_valid       (cfg_valid),
	.cfg_ready       (cfg_ready)
);
`default_nettype wire

@@ tb/sv/ptss_checker.sv @@
`timescale 1ns / 1ps
// result checker for the pan/tilt servo slew controller: watches the request, result and
// register channels, predicts every result word and compares it field by field
// depends on ptss_pkg
module ptss_checker
	import ptss_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [CELL_W-1:0]     grid_cell,
	input  wire logic [COORD_W-1:0]    track_x,
	input  wire logic [COORD_W-1:0]    track_y,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [PULSE_W-1:0]    pan_pulse_us,
	input  wire logic [PULSE_W-1:0]    tilt_pulse_us,
	input  wire logic [ANGLE_W-1:0]    pan_now,
	input  wire logic [ANGLE_W-1:0]    tilt_now,
	input  wire logic [MODE_W-1:0]     mode_now,
	input  wire logic                  request_ignored,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         pending,
	output int                         requests_seen,
	output int                         words_checked,
	output int                         timeouts_seen,
	output int                         reg_writes
);

	typedef struct packed {
		logic [PULSE_W-1:0] pan_pulse;
		logic [PULSE_W-1:0] tilt_pulse;
		logic [ANGLE_W-1:0] pan;
		logic [ANGLE_W-1:0] tilt;
		logic [MODE_W-1:0]  mode;
		logic               ignored;
	} servo_word_t;

	localparam logic [ANGLE_W-1:0] COL_PAN  [3] = '{8'd30, 8'd90, 8'd150};
	localparam logic [ANGLE_W-1:0] ROW_TILT [3] = '{8'd120, 8'd90, 8'd60};
	localparam int COORD_ONE = 1 << COORD_FRAC_BITS;

	logic [ANGLE_W-1:0] slew_step;
	logic [COUNT_W-1:0] timeout_ticks;
	logic [PULSE_W-1:0] pulse_lo;
	logic [PULSE_W-1:0] pulse_hi;
	logic               mirror_pan;
	logic               mirror_tilt;
	logic [ANGLE_W-1:0] home_deg;

	logic [MODE_W-1:0]  mode;
	logic [ANGLE_W-1:0] pan_deg;
	logic [ANGLE_W-1:0] tilt_deg;
	logic [ANGLE_W-1:0] pan_goal;
	logic [ANGLE_W-1:0] tilt_goal;
	logic [COUNT_W-1:0] ticks_idle;

	servo_word_t expected_words[$];
	servo_word_t want;

	function automatic logic [ANGLE_W-1:0] clamp_deg(logic [ANGLE_W-1:0] v);
		return (v > ANGLE_MAX) ? ANGLE_MAX : v;
	endfunction

	function automatic logic [ANGLE_W-1:0] slew_toward(logic [ANGLE_W-1:0] cur,
			logic [ANGLE_W-1:0] goal);
		if (cur < goal)
			return (goal - cur > slew_step) ? cur + slew_step : goal;
		if (cur > goal)
			return (cur - goal > slew_step) ? cur - slew_step : goal;
		return cur;
	endfunction

	function automatic logic [PULSE_W-1:0] pulse_for(logic [ANGLE_W-1:0] deg, logic mirror);
		int d;
		int span;
		d = int'(clamp_deg(deg));
		if (mirror)
			d = 180 - d;
		if (pulse_hi < pulse_lo)
			return pulse_lo;
		span = int'(pulse_hi) - int'(pulse_lo);
		return PULSE_W'(int'(pulse_lo) + (span * d + 90) / 180);
	endfunction

	function automatic logic [ANGLE_W-1:0] coord_deg(logic [COORD_W-1:0] v);
		int c;
		c = (int'(v) > COORD_ONE) ? COORD_ONE : int'(v);
		return ANGLE_W'((180 * c + COORD_ONE / 2) >> COORD_FRAC_BITS);
	endfunction

	function automatic void go_home();
		mode = CM_IDLE;
		pan_goal = clamp_deg(home_deg);
		tilt_goal = clamp_deg(home_deg);
	endfunction

	function automatic servo_word_t advance_servo(logic [REQ_W-1:0] req,
			logic [CELL_W-1:0] spot, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		servo_word_t w;
		logic ignored;
		int k;
		ignored = 1'b0;
		case (req)
		REQ_TICK: begin
			if (ticks_idle != '1)
				ticks_idle = ticks_idle + 1'b1;
			if (mode == CM_TRACK && ticks_idle > timeout_ticks) begin
				go_home();
				timeouts_seen++;
			end
			pan_deg = slew_toward(pan_deg, pan_goal);
			tilt_deg = slew_toward(tilt_deg, tilt_goal);
		end
		REQ_DEFAULT: go_home();
		REQ_GRID: begin
			if (spot >= 1 && spot <= 9) begin
				k = int'(spot) - 1;
				mode = CM_GRID;
				pan_goal = COL_PAN[k % 3];
				tilt_goal = ROW_TILT[k / 3];
			end else begin
				ignored = 1'b1;
			end
		end
		default: begin
			mode = CM_TRACK;
			pan_goal = coord_deg(x);
			tilt_goal = coord_deg(y);
			ticks_idle = '0;
		end
		endcase
		w.pan_pulse = pulse_for(pan_deg, mirror_pan);
		w.tilt_pulse = pulse_for(tilt_deg, mirror_tilt);
		w.pan = pan_deg;
		w.tilt = tilt_deg;
		w.mode = mode;
		w.ignored = ignored;
		return w;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_step = RST_STEP;
			timeout_ticks = RST_TIMEOUT;
			pulse_lo = RST_PULSE_MIN;
			pulse_hi = RST_PULSE_MAX;
			mirror_pan = 1'b1;
			mirror_tilt = 1'b1;
			home_deg = RST_DEFAULT;
			mode = CM_IDLE;
			pan_deg = RESET_ANGLE;
			tilt_deg = RESET_ANGLE;
			pan_goal = RESET_ANGLE;
			tilt_goal = RESET_ANGLE;
			ticks_idle = '0;
			expected_words.delete();
			fail_count = 0;
			requests_seen = 0;
			words_checked = 0;
			timeouts_seen = 0;
			reg_writes = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
				REG_STEP:        slew_step = cfg_data[ANGLE_W-1:0];
				REG_TIMEOUT:     timeout_ticks = cfg_data[COUNT_W-1:0];
				REG_PULSE_MIN:   pulse_lo = cfg_data[PULSE_W-1:0];
				REG_PULSE_MAX:   pulse_hi = cfg_data[PULSE_W-1:0];
				REG_INVERT_PAN:  mirror_pan = cfg_data[0];
				REG_INVERT_TILT: mirror_tilt = cfg_data[0];
				REG_DEFAULT:     home_deg = cfg_data[ANGLE_W-1:0];
				default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				requests_seen++;
				expected_words.push_back(advance_servo(req_type, grid_cell, track_x, track_y));
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("result word with no request waiting for it");
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					check_field("pan_pulse_us", want.pan_pulse, pan_pulse_us);
					check_field("tilt_pulse_us", want.tilt_pulse, tilt_pulse_us);
					check_field("pan_now", want.pan, pan_now);
					check_field("tilt_now", want.tilt, tilt_now);
					check_field("mode_now", want.mode, mode_now);
					check_field("request_ignored", want.ignored, request_ignored);
				end
			end
			pending <= expected_words.size();
		end
	end

endmodule

@@ tb/sv/pan_tilt_servo_slew_controller_core_tb.sv @@
`timescale 1ns / 1ps
// top of the pan/tilt servo slew controller testbench: clock, reset, stimulus and verdict
// depends on ptss_pkg, pan_tilt_servo_slew_controller_core and ptss_checker
module pan_tilt_servo_slew_controller_core_tb;
	import ptss_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int QUIET_LIMIT = 1000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic [REQ_W-1:0]      req_type = REQ_TICK;
	logic [CELL_W-1:0]     grid_cell = '0;
	logic [COORD_W-1:0]    track_x = '0;
	logic [COORD_W-1:0]    track_y = '0;
	logic                  out_stall = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_stall;
	logic                  out_valid;
	logic [PULSE_W-1:0]    pan_pulse_us;
	logic [PULSE_W-1:0]    tilt_pulse_us;
	logic [ANGLE_W-1:0]    pan_now;
	logic [ANGLE_W-1:0]    tilt_now;
	logic [MODE_W-1:0]     mode_now;
	logic                  request_ignored;
	logic                  cfg_ready;

	int fail_count;
	int pending;
	int requests_seen;
	int words_checked;
	int timeouts_seen;
	int reg_writes;

	// no idling at all in the last part of the run
	logic calm = 1'b0;
	logic idle_ok;
	int   cycle_no = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;

	// idling comes and goes in stretches: off in every third stretch, allowed in the other two
	assign idle_ok = !calm && ((cycle_no / 150) % 3 != 0);

	always #10 clk = ~clk;

	pan_tilt_servo_slew_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.grid_cell(grid_cell),
		.track_x(track_x),
		.track_y(track_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pan_pulse_us(pan_pulse_us),
		.tilt_pulse_us(tilt_pulse_us),
		.pan_now(pan_now),
		.tilt_now(tilt_now),
		.mode_now(mode_now),
		.request_ignored(request_ignored),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ptss_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.grid_cell(grid_cell),
		.track_x(track_x),
		.track_y(track_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pan_pulse_us(pan_pulse_us),
		.tilt_pulse_us(tilt_pulse_us),
		.pan_now(pan_now),
		.tilt_now(tilt_now),
		.mode_now(mode_now),
		.request_ignored(request_ignored),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending),
		.requests_seen(requests_seen),
		.words_checked(words_checked),
		.timeouts_seen(timeouts_seen),
		.reg_writes(reg_writes)
	);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (!idle_ok) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 3) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles in which no word moves on any channel
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("pan_tilt_servo_slew_controller_core_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(logic [REQ_W-1:0] req, logic [CELL_W-1:0] spot,
			logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		if (idle_ok && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		grid_cell <= spot;
		track_x <= x;
		track_y <= y;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		// pulse stages behind the angle state
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value, int width);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		// junk above the register width must be dropped
		cfg_data <= (CFG_DATA_W'($urandom) << width) | CFG_DATA_W'(value);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic program_regs(int step, int tmo, int pmin, int pmax, int inv_p, int inv_t,
			int home);
		write_reg(REG_STEP, step, ANGLE_W);
		write_reg(REG_TIMEOUT, tmo, COUNT_W);
		write_reg(REG_PULSE_MIN, pmin, PULSE_W);
		write_reg(REG_PULSE_MAX, pmax, PULSE_W);
		write_reg(REG_INVERT_PAN, inv_p, 1);
		write_reg(REG_INVERT_TILT, inv_t, 1);
		write_reg(REG_DEFAULT, home, ANGLE_W);
		write_reg(REG_SPARE, $urandom, CFG_DATA_W);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		if ($urandom_range(0, 3) == 0)
			return COORD_W'($urandom_range(0, 8191));
		return COORD_W'($urandom_range(0, 1 << COORD_FRAC_BITS));
	endfunction

	task automatic random_requests(int count);
		int left;
		int burst;
		int pick;
		left = count;
		while (left > 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				// long tick runs so that track mode can time out
				burst = $urandom_range(1, 60);
				if (burst > left)
					burst = left;
				repeat (burst)
					send_word(REQ_TICK, CELL_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom));
				left -= burst;
			end else begin
				if (pick < 60)
					send_word(REQ_TICK, CELL_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom));
				else if (pick < 75)
					send_word(REQ_TRACK, CELL_W'($urandom), rand_coord(), rand_coord());
				else if (pick < 90)
					send_word(REQ_GRID, ($urandom_range(0, 3) == 0) ?
						CELL_W'($urandom) : CELL_W'($urandom_range(1, 9)),
						COORD_W'($urandom), COORD_W'($urandom));
				else
					send_word(REQ_DEFAULT, CELL_W'($urandom), COORD_W'($urandom),
						COORD_W'($urandom));
				left--;
			end
		end
	endtask

	task automatic run_phase(int step, int tmo, int pmin, int pmax, int inv_p, int inv_t,
			int home, int count);
		wait_drain();
		program_regs(step, tmo, pmin, pmax, inv_p, inv_t, home);
		random_requests(count);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: grid corners, invalid cells, track corners and clamping
		send_word(REQ_TICK, 0, 0, 0);
		send_word(REQ_GRID, 1, 0, 0);
		send_word(REQ_TICK, 0, 0, 0);
		send_word(REQ_GRID, 9, 0, 0);
		send_word(REQ_TICK, 15, 8191, 8191);
		send_word(REQ_GRID, 5, 0, 0);
		send_word(REQ_GRID, 0, 0, 0);
		send_word(REQ_GRID, 10, 0, 0);
		send_word(REQ_GRID, 15, 8191, 8191);
		send_word(REQ_TRACK, 0, 0, 0);
		send_word(REQ_TICK, 0, 0, 0);
		send_word(REQ_TRACK, 0, 4096, 4096);
		send_word(REQ_TICK, 0, 0, 0);
		send_word(REQ_TRACK, 15, 8191, 8191);
		send_word(REQ_TRACK, 0, 4097, 2048);
		send_word(REQ_DEFAULT, 15, 8191, 8191);
		send_word(REQ_TICK, 0, 0, 0);
		send_word(REQ_GRID, 3, 0, 0);
		send_word(REQ_GRID, 7, 0, 0);
		send_word(REQ_TICK, 0, 0, 0);
		send_word(REQ_TICK, 0, 0, 0);

		run_phase(3, 50, 1000, 2000, 1, 1, 90, 300);

		// full pulse span, oversized step, zero timeout
		wait_drain();
		program_regs(255, 0, 0, 4095, 0, 0, 0);
		send_word(REQ_TRACK, 0, 4096, 0);
		send_word(REQ_TICK, 0, 0, 0);
		send_word(REQ_TICK, 0, 0, 0);
		random_requests(200);

		// frozen angles, inverted pulse range, home angle past 180
		run_phase(0, 65535, 4095, 0, 1, 0, 255, 150);
		run_phase(180, 1, 500, 2500, 0, 1, 180, 300);

		repeat (3)
			run_phase($urandom_range(1, 30), $urandom_range(0, 20), $urandom_range(0, 2000),
				$urandom_range(1500, 4095), $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 200), 200);

		calm <= 1'b1;
		run_phase($urandom_range(1, 30), $urandom_range(0, 20), $urandom_range(0, 2000),
			$urandom_range(1500, 4095), $urandom_range(0, 1), $urandom_range(0, 1),
			$urandom_range(0, 200), 250);

		wait_drain();
		repeat (4) @(posedge clk);
		$display("covered %0d requests across %0d register writes, track timeout taken %0d times",
			requests_seen, reg_writes, timeouts_seen);
		$display("compared %0d result words, %0d mismatches", words_checked, fail_count);
		if (fail_count == 0)
			$display("pan_tilt_servo_slew_controller_core_tb passed");
		else
			$display("pan_tilt_servo_slew_controller_core_tb failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/ptss_pkg.sv
hdl/ptss_ctrl.sv
hdl/ptss_axis_lane.sv
hdl/ptss_merge.sv
hdl/pan_tilt_servo_slew_controller_core.sv
hdl/ptss_checker.sv
tb/sv/ptss_checker.sv
tb/sv/pan_tilt_servo_slew_controller_core_tb.sv
